### rtl/mesh_face_dedup_table_unit_macros.svh
// ----------------------------------------------------------------------------
// mesh_face_dedup_table_unit_macros
// Assertion macros used by the checker file mfd_checker.
// ----------------------------------------------------------------------------
`ifndef MESH_FACE_DEDUP_TABLE_UNIT_MACROS_SVH
`define MESH_FACE_DEDUP_TABLE_UNIT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define MFD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define MFD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/mfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfd_pkg
// Shared types and constants of the face deduplication table.
// ----------------------------------------------------------------------------
package mfd_pkg;

    localparam int TABLE_DEPTH = 4096;
    localparam int NODE_BITS   = 20;
    localparam int IDX_BITS    = $clog2(TABLE_DEPTH);
    localparam int CNT_BITS    = IDX_BITS + 1;
    localparam int FACE_BITS   = 3 * NODE_BITS;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_COUNT  = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_EMIT
    } mfd_state_t;

    // Sorted face triple, smallest node first.
    typedef struct packed {
        logic [NODE_BITS-1:0] n0;
        logic [NODE_BITS-1:0] n1;
        logic [NODE_BITS-1:0] n2;
    } face_t;

    // Memory access request from the controller.
    typedef struct packed {
        logic                rd_en;
        logic [IDX_BITS-1:0] rd_addr;
        logic                wr_en;
        logic [IDX_BITS-1:0] wr_addr;
        face_t               wr_data;
    } mem_req_t;

    function automatic face_t sort3(input logic [NODE_BITS-1:0] x,
                                    input logic [NODE_BITS-1:0] y,
                                    input logic [NODE_BITS-1:0] z);
        logic [NODE_BITS-1:0] a;
        logic [NODE_BITS-1:0] b;
        logic [NODE_BITS-1:0] c;
        logic [NODE_BITS-1:0] t;
        face_t                r;
        a = x;
        b = y;
        c = z;
        if (a > b) begin t = a; a = b; b = t; end
        if (b > c) begin t = b; b = c; c = t; end
        if (a > b) begin t = a; a = b; b = t; end
        r.n0 = a;
        r.n1 = b;
        r.n2 = c;
        return r;
    endfunction

endpackage

### rtl/mfd_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfd_store
// Face memory: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mfd_store (
    input  logic            clk,
    input  mfd_pkg::mem_req_t req,
    output mfd_pkg::face_t  rd_data
);
    import mfd_pkg::*;

    face_t mem [TABLE_DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    // Read port, with registered read data.
    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data <= mem[req.rd_addr];
        end
    end

endmodule

### rtl/mfd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfd_ctrl
// Sequencer that scans the table for each face and appends missing faces on an insert.
// ----------------------------------------------------------------------------
module mfd_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    command,
    input  logic [19:0]                   node_a,
    input  logic [19:0]                   node_b,
    input  logic [19:0]                   node_c,
    input  logic [19:0]                   node_d,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [1:0]                    face_slot,
    output logic [11:0]                   face_index,
    output logic                          is_new,
    output logic                          matched,
    output logic                          table_full,
    output logic [2:0]                    shared_count,
    output logic                          last,
    output mfd_pkg::mem_req_t             mem_req,
    input  mfd_pkg::face_t                rd_data
);
    import mfd_pkg::*;

    mfd_state_t state_reg, state_next;

    logic [NODE_BITS-1:0] node_reg [4];
    logic [NODE_BITS-1:0] node_next [4];
    logic                 ins_reg, ins_next;
    logic [1:0]           slot_reg, slot_next;
    logic [CNT_BITS-1:0]  count_reg, count_next;
    logic [CNT_BITS-1:0]  scan_reg, scan_next;
    logic [2:0]           shared_reg, shared_next;
    logic [11:0]          idx_reg, idx_next;
    logic                 new_reg, new_next;
    logic                 match_reg, match_next;
    logic                 full_reg, full_next;
    logic                 hit;
    face_t                face;
    logic                 accept;

    assign accept = in_valid && !in_stall;

    // Current face, sorted.
    always_comb
    begin
        case (slot_reg)
            2'd0:    face = sort3(node_reg[0], node_reg[1], node_reg[2]);
            2'd1:    face = sort3(node_reg[1], node_reg[2], node_reg[3]);
            2'd2:    face = sort3(node_reg[2], node_reg[3], node_reg[0]);
            default: face = sort3(node_reg[3], node_reg[0], node_reg[1]);
        endcase
    end

    assign hit = (rd_data == face);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (command == CMD_INSERT || command == CMD_COUNT))
                begin
                    state_next = (count_reg == '0) ? ST_EMIT : ST_READ;
                end
            end
            ST_READ:  state_next = ST_CHECK;
            ST_CHECK:
            begin
                if (hit || (scan_reg + 1'b1) >= count_reg)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_READ;
                end
            end
            ST_EMIT:
            begin
                if (!out_stall)
                begin
                    if (slot_reg == 2'd3)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = (count_next == '0) ? ST_EMIT : ST_READ;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath and memory control.
    always_comb
    begin
        node_next   = node_reg;
        ins_next    = ins_reg;
        slot_next   = slot_reg;
        count_next  = count_reg;
        scan_next   = scan_reg;
        shared_next = shared_reg;
        idx_next    = idx_reg;
        new_next    = new_reg;
        match_next  = match_reg;
        full_next   = full_reg;
        mem_req     = '0;
        mem_req.rd_addr = scan_reg[IDX_BITS-1:0];
        mem_req.wr_addr = count_reg[IDX_BITS-1:0];
        mem_req.wr_data = face;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (command == CMD_CLEAR)
                    begin
                        count_next = '0;
                    end
                    node_next[0] = node_a[NODE_BITS-1:0];
                    node_next[1] = node_b[NODE_BITS-1:0];
                    node_next[2] = node_c[NODE_BITS-1:0];
                    node_next[3] = node_d[NODE_BITS-1:0];
                    ins_next    = (command == CMD_INSERT);
                    slot_next   = 2'd0;
                    scan_next   = '0;
                    shared_next = '0;
                    // Empty table: face resolves as a miss without a scan.
                    idx_next    = '0;
                    new_next    = 1'b0;
                    match_next  = 1'b0;
                    full_next   = 1'b0;
                end
            end
            ST_READ:
            begin
                mem_req.rd_en = 1'b1;
            end
            ST_CHECK:
            begin
                scan_next = scan_reg + 1'b1;
                if (hit)
                begin
                    match_next  = 1'b1;
                    idx_next    = 12'(scan_reg);
                    shared_next = shared_reg + 3'd1;
                end
            end
            ST_EMIT:
            begin
                if (!out_stall)
                begin
                    // The new face is appended when its result is taken.
                    if (new_reg)
                    begin
                        count_next    = count_reg + 1'b1;
                        mem_req.wr_en = 1'b1;
                    end
                    slot_next  = slot_reg + 2'd1;
                    scan_next  = '0;
                    idx_next   = '0;
                    new_next   = 1'b0;
                    match_next = 1'b0;
                    full_next  = 1'b0;
                end
            end
            default: ;
        endcase
        // A miss resolves on entry to the result state.
        if ((state_reg == ST_CHECK && !hit && (scan_reg + 1'b1) >= count_reg) ||
            (state_reg == ST_IDLE && accept && count_reg == '0 &&
             (command == CMD_INSERT)))
        begin
            if (!(state_reg == ST_IDLE) ? ins_reg : 1'b1)
            begin
                if (count_reg < CNT_BITS'(TABLE_DEPTH))
                begin
                    new_next   = 1'b1;
                    idx_next   = 12'(count_reg);
                end
                else
                begin
                    full_next  = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg   <= node_next;
        ins_reg    <= ins_next;
        slot_reg   <= slot_next;
        scan_reg   <= scan_next;
        shared_reg <= shared_next;
        idx_reg    <= idx_next;
        new_reg    <= new_next;
        match_reg  <= match_next;
        full_reg   <= full_next;
    end

    // Outputs.
    always_comb
    begin
        in_stall     = (state_reg != ST_IDLE);
        out_valid    = (state_reg == ST_EMIT);
        face_slot    = slot_reg;
        face_index   = idx_reg;
        is_new       = new_reg;
        matched      = match_reg;
        table_full   = full_reg;
        shared_count = shared_reg;
        last         = (slot_reg == 2'd3);
    end

endmodule

### rtl/mesh_face_dedup_table_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mesh_face_dedup_table_unit
// Looks up the four faces of a tetrahedron in a table of unique triples.
// ----------------------------------------------------------------------------
//  channel | signals                                | direction
//  in      | in_valid/in_stall, command, node_a..d  | request in
//  out     | out_valid/out_stall, face_slot..last   | result out
//
// A request is taken while idle; a clear or an unused command ends there.
// Each face then scans the table entry by entry (memory read, compare) up to
// the first match and then presents its result, which waits while out_stall
// is high. New input stalls until the last result of an item is taken.
// Results come out one per face; a stalled result holds the sequencer.
// Reset empties the table; no clearing pass is needed.
module mesh_face_dedup_table_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  command,
    input  logic [19:0] node_a,
    input  logic [19:0] node_b,
    input  logic [19:0] node_c,
    input  logic [19:0] node_d,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  face_slot,
    output logic [11:0] face_index,
    output logic        is_new,
    output logic        matched,
    output logic        table_full,
    output logic [2:0]  shared_count,
    output logic        last
);
    import mfd_pkg::*;

    mem_req_t req;
    face_t    rd_data;

    mfd_ctrl u_ctrl (
        .clk, .rst_n, .in_valid, .in_stall, .command,
        .node_a, .node_b, .node_c, .node_d,
        .out_valid, .out_stall, .face_slot, .face_index, .is_new,
        .matched, .table_full, .shared_count, .last,
        .mem_req(req), .rd_data
    );

    mfd_store u_store (
        .clk, .req, .rd_data
    );

endmodule

### rtl/mfd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfd_checker
// Port-level checks on the face deduplication table.
// ----------------------------------------------------------------------------
`include "mesh_face_dedup_table_unit_macros.svh"

module mfd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic        is_new,
    input logic        matched,
    input logic        table_full,
    input logic [2:0]  shared_count,
    input logic        last
);
    `MFD_ASSERT_IMPL(a_flags_excl, clk, rst_n, out_valid,
        !(is_new && matched) && !(is_new && table_full) && !(matched && table_full),
        "result flags overlap")
    `MFD_ASSERT_IMPL(a_shared_range, clk, rst_n, out_valid, shared_count <= 3'd4,
        "shared count out of range")
    `MFD_ASSERT_IMPL(a_busy_no_take, clk, rst_n, out_valid, in_stall,
        "input taken while results pending")
    `MFD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid,
        "stalled result dropped")
    `MFD_ASSERT_NEXT(a_last_ends, clk, rst_n, out_valid && !out_stall && last, !out_valid,
        "result after the last face")
endmodule

bind mesh_face_dedup_table_unit mfd_checker u_mfd_checker (
    .clk, .rst_n, .in_stall, .out_valid, .out_stall,
    .is_new, .matched, .table_full, .shared_count, .last
);
